// ===== hdl/pcrg_pkg.sv =====
// ----------------------------------------------------------------------------
// pcrg_pkg
// Shared widths, register indexes, the divider stage record and its step.
// ----------------------------------------------------------------------------
package pcrg_pkg;

    localparam int PW     = 10;
    localparam int GW     = 10;
    localparam int PTW    = GW + 1;
    localparam int FW     = 20;
    localparam int PACK_W = 3 * FW;
    localparam int EW     = GW + 3;
    localparam int DW     = GW + 2;
    localparam int QW     = FW + 1;
    localparam int UW     = FW + EW;
    localparam int NW     = UW + 1;
    localparam int PRW    = PW + 1;
    localparam int IW     = PW + 1;
    localparam int MW     = FW + IW;
    localparam int SW     = MW + 2;
    localparam int OW     = 32;
    localparam int CFG_IW = 3;

    localparam logic [PW-1:0] END_RST = PW'(1023);

    localparam logic [CFG_IW-1:0] REG_ORIGIN   = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] REG_STEP     = CFG_IW'(1);
    localparam logic [CFG_IW-1:0] REG_START    = CFG_IW'(2);
    localparam logic [CFG_IW-1:0] REG_END      = CFG_IW'(3);
    localparam logic [CFG_IW-1:0] REG_ACTIVE   = CFG_IW'(4);
    localparam logic [CFG_IW-1:0] REG_INACTIVE = CFG_IW'(5);
    localparam logic [CFG_IW-1:0] REG_HALF     = CFG_IW'(6);

    typedef struct packed {
        logic [2:0][DW-1:0] rem;
        logic [2:0][QW-1:0] quo;
        logic [2:0]         neg;
        logic [PTW-1:0]     pts;
        logic [PRW-1:0]     prem;
        logic [QW-1:0]      pquo;
        logic               first;
        logic               win;
    } t_div;

    function automatic logic signed [FW-1:0] axis_field(logic [PACK_W-1:0] pk, int axis);
        return pk[FW*axis +: FW];
    endfunction

    function automatic t_div div_step(t_div s, logic [PRW-1:0] period);
        t_div         o;
        logic [DW:0]  t;
        logic [DW:0]  d;
        logic [DW:0]  diff;
        logic [PRW:0] tp;
        logic [PRW:0] dp;
        o = s;
        d = {1'b0, s.pts, 1'b0};
        for (int k = 0; k < 3; k++) begin
            t = {s.rem[k], s.quo[k][QW-1]};
            o.quo[k] = {s.quo[k][QW-2:0], 1'b0};
            if (t >= d) begin
                diff        = t - d;
                o.rem[k]    = diff[DW-1:0];
                o.quo[k][0] = 1'b1;
            end else begin
                o.rem[k] = t[DW-1:0];
            end
        end
        tp = {s.prem, s.pquo[QW-1]};
        o.pquo = {s.pquo[QW-2:0], 1'b0};
        if (tp >= {1'b0, period}) begin
            dp        = tp - {1'b0, period};
            o.prem    = dp[PRW-1:0];
            o.pquo[0] = 1'b1;
        end else begin
            o.prem = tp[PRW-1:0];
        end
        return o;
    endfunction

endpackage

// ===== hdl/pcrg_item_if.sv =====
// ----------------------------------------------------------------------------
// pcrg_item_if
// Input channel: contact phase, grid count and grid points per transfer.
// ----------------------------------------------------------------------------
interface pcrg_item_if;
    logic                      valid;
    logic                      ready;
    logic [pcrg_pkg::PW-1:0]   phase_idx;
    logic [pcrg_pkg::GW-1:0]   grid_index;
    logic [pcrg_pkg::PTW-1:0]  grid_points;

    modport source (output valid, phase_idx, grid_index, grid_points, input ready);
    modport sink   (input valid, phase_idx, grid_index, grid_points, output ready);
endinterface

// ===== hdl/pcrg_result_if.sv =====
// ----------------------------------------------------------------------------
// pcrg_result_if
// Result channel: three-axis reference with active and saturation flags.
// ----------------------------------------------------------------------------
interface pcrg_result_if;
    logic                            valid;
    logic                            ready;
    logic signed [pcrg_pkg::OW-1:0]  ref_x;
    logic signed [pcrg_pkg::OW-1:0]  ref_y;
    logic signed [pcrg_pkg::OW-1:0]  ref_z;
    logic                            is_active;
    logic                            saturated;

    modport source (output valid, ref_x, ref_y, ref_z, is_active, saturated, input ready);
    modport sink   (input valid, ref_x, ref_y, ref_z, is_active, saturated, output ready);
endinterface

// ===== hdl/pcrg_div_stage.sv =====
// ----------------------------------------------------------------------------
// pcrg_div_stage
// One registered restoring-division step for the three axes and the phase.
// ----------------------------------------------------------------------------
module pcrg_div_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [pcrg_pkg::PRW-1:0]    i_period,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  pcrg_pkg::t_div              i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output pcrg_pkg::t_div              o_data
);

    logic           r_valid;
    pcrg_pkg::t_div r_data;
    pcrg_pkg::t_div n_data;

    assign o_ready = !r_valid || i_ready;
    assign n_data  = pcrg_pkg::div_step(i_data, i_period);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/periodic_com_reference_generator.sv =====
// ----------------------------------------------------------------------------
// periodic_com_reference_generator
// Periodic center-of-mass reference: origin plus a fractional number of steps.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// i_item    in   phase_idx, grid_index, grid_points
// o_result  out  ref_x, ref_y, ref_z, is_active, saturated
// i_cfg_*   in   write enable, register index, 60-bit data
//
// One transfer is accepted per cycle while the result channel does not stall;
// the pipeline is the 21-step restoring divider plus four arithmetic stages.
// Reset clears all valid bits and loads the register defaults.
// Every stage holds its item while the next one is full, so bubbles collapse.
// ----------------------------------------------------------------------------
module periodic_com_reference_generator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pcrg_item_if.sink                      i_item,
    pcrg_result_if.source                  o_result,
    input  logic                           i_cfg_we,
    input  logic [pcrg_pkg::CFG_IW-1:0]    i_cfg_index,
    input  logic [pcrg_pkg::PACK_W-1:0]    i_cfg_data
);

    localparam int PW  = pcrg_pkg::PW;
    localparam int PTW = pcrg_pkg::PTW;
    localparam int EW  = pcrg_pkg::EW;
    localparam int QW  = pcrg_pkg::QW;
    localparam int UW  = pcrg_pkg::UW;
    localparam int NW  = pcrg_pkg::NW;
    localparam int PRW = pcrg_pkg::PRW;
    localparam int IW  = pcrg_pkg::IW;
    localparam int MW  = pcrg_pkg::MW;
    localparam int SW  = pcrg_pkg::SW;
    localparam int OW  = pcrg_pkg::OW;

    logic [pcrg_pkg::PACK_W-1:0] r_origin;
    logic [pcrg_pkg::PACK_W-1:0] r_step;
    logic [PW-1:0]               r_start;
    logic [PW-1:0]               r_end;
    logic [PW-1:0]               r_act;
    logic [PW-1:0]               r_inact;
    logic                        r_half;
    logic [PRW-1:0]              period_sum;
    logic [PRW-1:0]              period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin <= '0;
            r_step   <= '0;
            r_start  <= '0;
            r_end    <= pcrg_pkg::END_RST;
            r_act    <= PW'(1);
            r_inact  <= PW'(1);
            r_half   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pcrg_pkg::REG_ORIGIN:   r_origin <= i_cfg_data;
                pcrg_pkg::REG_STEP:     r_step   <= i_cfg_data;
                pcrg_pkg::REG_START:    r_start  <= i_cfg_data[PW-1:0];
                pcrg_pkg::REG_END:      r_end    <= i_cfg_data[PW-1:0];
                pcrg_pkg::REG_ACTIVE:   r_act    <= i_cfg_data[PW-1:0];
                pcrg_pkg::REG_INACTIVE: r_inact  <= i_cfg_data[PW-1:0];
                pcrg_pkg::REG_HALF:     r_half   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign period_sum = PRW'(r_act) + PRW'(r_inact);
    assign period     = (period_sum == '0) ? PRW'(1) : period_sum;

    // Handshake chain.
    logic r_v0, r_v1, r_v2, r_v3;
    logic rdy0, rdy1, rdy2, rdy3;
    logic div_v   [0:QW];
    logic div_rdy [0:QW];
    pcrg_pkg::t_div div_d [0:QW];

    assign rdy3         = !r_v3 || o_result.ready;
    assign rdy2         = !r_v2 || rdy3;
    assign div_rdy[QW]  = rdy2;
    assign rdy1         = !r_v1 || div_rdy[0];
    assign rdy0         = !r_v0 || rdy1;
    assign i_item.ready = rdy0;

    // Stage 0: clamp the count, classify the phase, form the step multiplier.
    logic [PTW-1:0] n_pts, n_cnt;
    logic [PW-1:0]  n_a;
    logic           n_prestart, n_first, n_inend;
    logic [EW-1:0]  n_e;
    logic [EW-1:0]  r_s0_e;
    logic [PTW-1:0] r_s0_pts;
    logic [PW-1:0]  r_s0_a;
    logic           r_s0_first, r_s0_win;

    always_comb begin
        n_pts      = (i_item.grid_points == '0) ? PTW'(1) : i_item.grid_points;
        n_cnt      = ({1'b0, i_item.grid_index} > i_item.grid_points) ?
                     i_item.grid_points : {1'b0, i_item.grid_index};
        n_prestart = i_item.phase_idx < r_start;
        n_a        = i_item.phase_idx - r_start;
        n_first    = n_prestart || (n_a < r_act);
        n_inend    = i_item.phase_idx < r_end;
        if (r_half) begin
            n_e = n_first ? EW'(n_cnt) : EW'(n_pts) + EW'({n_cnt, 1'b0});
        end else begin
            n_e = EW'({n_cnt, 1'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (rdy0) begin
            r_v0 <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_s0_e     <= n_e;
            r_s0_pts   <= n_pts;
            r_s0_a     <= n_a;
            r_s0_first <= n_first;
            r_s0_win   <= !n_prestart && n_inend;
        end
    end

    // Stage 1: dividend step*E + points, folded to a magnitude for floor division.
    pcrg_pkg::t_div          n_s1;
    pcrg_pkg::t_div          r_s1;
    logic signed [NW-1:0]    n_prod [3];
    logic [NW-1:0]           n_un   [3];

    always_comb begin
        n_s1       = '0;
        n_s1.pts   = r_s0_pts;
        n_s1.prem  = '0;
        n_s1.pquo  = QW'(r_s0_a);
        n_s1.first = r_s0_first;
        n_s1.win   = r_s0_win;
        for (int k = 0; k < 3; k++) begin
            n_prod[k] = NW'(pcrg_pkg::axis_field(r_step, k)) * NW'($signed({1'b0, r_s0_e}))
                        + NW'($signed({1'b0, r_s0_pts}));
            n_s1.neg[k] = n_prod[k][NW-1];
            n_un[k]     = n_prod[k][NW-1] ? ~n_prod[k] : n_prod[k];
            n_s1.rem[k] = n_un[k][UW-1:QW];
            n_s1.quo[k] = n_un[k][QW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1 <= n_s1;
        end
    end

    assign div_v[0] = r_v1;
    assign div_d[0] = r_s1;

    for (genvar g = 0; g < QW; g++) begin : g_div
        pcrg_div_stage u_stage (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_period (period),
            .i_valid  (div_v[g]),
            .o_ready  (div_rdy[g]),
            .i_data   (div_d[g]),
            .o_valid  (div_v[g+1]),
            .i_ready  (div_rdy[g+1]),
            .o_data   (div_d[g+1])
        );
    end

    // Stage 2: whole cycles times step, signed fractional part, active flag.
    pcrg_pkg::t_div          dq;
    logic                    n_ge;
    logic [IW-1:0]           n_i, n_cyc;
    logic signed [MW-1:0]    n_mul [3];
    logic signed [QW:0]      n_qs  [3];
    logic signed [MW-1:0]    r_s2_mul [3];
    logic signed [QW:0]      r_s2_qs  [3];
    logic                    r_s2_act;

    assign dq = div_d[QW];

    always_comb begin
        n_ge = dq.prem >= {1'b0, r_act};
        n_i  = IW'(dq.pquo[PW-1:0]) + IW'(n_ge);
        if (dq.first) begin
            n_cyc = '0;
        end else if (r_half) begin
            n_cyc = n_i - IW'(1);
        end else begin
            n_cyc = n_i;
        end
        for (int k = 0; k < 3; k++) begin
            n_mul[k] = MW'(pcrg_pkg::axis_field(r_step, k)) * MW'($signed({1'b0, n_cyc}));
            n_qs[k]  = dq.neg[k] ? $signed(~{1'b0, dq.quo[k]}) : $signed({1'b0, dq.quo[k]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= div_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_mul <= n_mul;
            r_s2_qs  <= n_qs;
            r_s2_act <= dq.win && !n_ge;
        end
    end

    // Stage 3: add the origin and saturate.
    logic signed [SW-1:0] n_sum [3];
    logic signed [OW-1:0] n_ref [3];
    logic [2:0]           n_clip;
    logic signed [OW-1:0] r_ref [3];
    logic                 r_active, r_sat;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_sum[k] = SW'(pcrg_pkg::axis_field(r_origin, k)) + SW'(r_s2_mul[k])
                       + SW'(r_s2_qs[k]);
            n_clip[k] = !((&n_sum[k][SW-1:OW-1]) || !(|n_sum[k][SW-1:OW-1]));
            if (!n_clip[k]) begin
                n_ref[k] = n_sum[k][OW-1:0];
            end else if (n_sum[k][SW-1]) begin
                n_ref[k] = {1'b1, {(OW-1){1'b0}}};
            end else begin
                n_ref[k] = {1'b0, {(OW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_ref    <= n_ref;
            r_active <= r_s2_act;
            r_sat    <= |n_clip;
        end
    end

    assign o_result.valid     = r_v3;
    assign o_result.ref_x     = r_ref[0];
    assign o_result.ref_y     = r_ref[1];
    assign o_result.ref_z     = r_ref[2];
    assign o_result.is_active = r_active;
    assign o_result.saturated = r_sat;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> r_v0)
        else $error("accepted transfer did not enter the first stage");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r_s1.rem[0] < {r_s1.pts, 1'b0}) && (r_s1.rem[1] < {r_s1.pts, 1'b0})
                 && (r_s1.rem[2] < {r_s1.pts, 1'b0}))
        else $error("initial partial remainder not below the divisor");

    a_phase_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_v[QW] |-> dq.prem < period)
        else $error("phase remainder not below the period");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && r_sat |-> (r_ref[0] == 32'sh7fffffff) || (r_ref[0] == 32'sh80000000)
                          || (r_ref[1] == 32'sh7fffffff) || (r_ref[1] == 32'sh80000000)
                          || (r_ref[2] == 32'sh7fffffff) || (r_ref[2] == 32'sh80000000))
        else $error("saturation flagged without a clipped axis");

endmodule
